[rtl/core/ccfr_pkg.sv]
// Shared types, constants and the CRC step for the frame receiver.
package ccfr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic [7:0]  SYNC_BYTE      = 8'h02;
  localparam logic [15:0] CRC_POLY       = 16'h8408;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd5;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20;
  localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADLEN  = 3'd2,
    KIND_CRCERR  = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN,
    PH_DATA,
    PH_CRCL,
    PH_CRCH
  } phase_t;

  // Classified input event, as queued between front and back.
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
    logic       is_sync;
    logic       len_short;
    logic [7:0] len_m5;
  } event_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] frame_address;
    logic [7:0] payload_length;
  } result_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Reflected CRC-16 over one byte, LSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/ccfr_front.sv]
// Front end: takes input transfers and classifies them into queue events.
module ccfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [7:0]          in_rx_byte,
  input  ccfr_pkg::q_status_t q_status,
  output logic                q_push,
  output ccfr_pkg::event_t    q_event
);

  logic accepted_r;
  logic accepted_nxt;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_event.is_tick   = in_func;
    q_event.rx_byte   = in_rx_byte;
    q_event.is_sync   = (in_rx_byte == ccfr_pkg::SYNC_BYTE);
    q_event.len_short = (in_rx_byte < ccfr_pkg::FRAME_OVERHEAD);
    q_event.len_m5    = in_rx_byte - ccfr_pkg::FRAME_OVERHEAD;
  end

  assign accepted_nxt = q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_r <= 1'b0;
    end else begin
      accepted_r <= accepted_nxt;
    end
  end

  // A transfer always lands in the queue, so the queue cannot be empty next cycle
  // unless the back drained it.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    accepted_r |-> $past(in_valid) && $past(in_ready))
    else $error("accept flag without transfer");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_event.is_sync == (in_rx_byte == ccfr_pkg::SYNC_BYTE)))
    else $error("sync classification mismatch");

endmodule

[rtl/core/ccfr_queue.sv]
// Short event queue between the front and the back.
module ccfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ccfr_pkg::event_t    push_event,
  input  logic                pop,
  output ccfr_pkg::event_t    head_event,
  output ccfr_pkg::q_status_t status
);

  ccfr_pkg::event_t mem_r [ccfr_pkg::QUEUE_DEPTH];

  logic [ccfr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ccfr_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ccfr_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [ccfr_pkg::QCNT_W-1:0] DEPTH_CNT = ccfr_pkg::QCNT_W'(ccfr_pkg::QUEUE_DEPTH);

  assign status.full  = (cnt_r == DEPTH_CNT);
  assign status.empty = (cnt_r == '0);
  assign head_event   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_event;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_CNT)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[ccfr_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

[rtl/core/ccfr_back.sv]
// Back end: deframing state machine, CRC check, timeout and result register.
module ccfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  ccfr_pkg::q_status_t q_status,
  input  ccfr_pkg::event_t    q_event,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ccfr_pkg::result_t   out_result
);

  ccfr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [15:0] silence_r, silence_nxt;
  logic        out_valid_r, out_valid_nxt;
  ccfr_pkg::result_t res_r, res_nxt;

  logic        emit;
  ccfr_pkg::result_t res;
  logic [15:0] sil_inc;
  logic [15:0] crc_upd;
  logic [7:0]  cnt_inc;
  logic        timed_out;
  logic        crc_match;

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  assign q_pop     = !q_status.empty && (!out_valid_r || out_ready);
  assign sil_inc   = (silence_r == ccfr_pkg::SILENCE_MAX) ? silence_r : silence_r + 16'd1;
  assign timed_out = (sil_inc >= timeout_r);
  assign crc_upd   = ccfr_pkg::crc_step(q_event.is_sync && (phase_r == ccfr_pkg::PH_HUNT)
                                        ? 16'h0000 : crc_r, q_event.rx_byte);
  assign cnt_inc   = byte_count_r + 8'd1;
  assign crc_match = ({q_event.rx_byte, crc_low_r} == crc_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      if (q_event.is_tick) begin
        if (phase_r != ccfr_pkg::PH_HUNT && timed_out) begin
          phase_nxt = ccfr_pkg::PH_HUNT;
        end
      end else begin
        case (phase_r)
          ccfr_pkg::PH_HUNT: if (q_event.is_sync) phase_nxt = ccfr_pkg::PH_ADDR;
          ccfr_pkg::PH_ADDR: phase_nxt = ccfr_pkg::PH_LEN;
          ccfr_pkg::PH_LEN: begin
            if (q_event.len_short) begin
              phase_nxt = ccfr_pkg::PH_HUNT;
            end else if (q_event.len_m5 != 8'd0) begin
              phase_nxt = ccfr_pkg::PH_DATA;
            end else begin
              phase_nxt = ccfr_pkg::PH_CRCL;
            end
          end
          ccfr_pkg::PH_DATA: if (cnt_inc >= frame_len_r) phase_nxt = ccfr_pkg::PH_CRCL;
          ccfr_pkg::PH_CRCL: phase_nxt = ccfr_pkg::PH_CRCH;
          ccfr_pkg::PH_CRCH: phase_nxt = ccfr_pkg::PH_HUNT;
          default:           phase_nxt = ccfr_pkg::PH_HUNT;
        endcase
      end
    end
  end

  // Datapath and result
  always_comb begin
    frame_len_nxt      = frame_len_r;
    byte_count_nxt     = byte_count_r;
    crc_nxt            = crc_r;
    crc_low_nxt        = crc_low_r;
    addr_nxt           = addr_r;
    silence_nxt        = silence_r;
    emit               = 1'b0;
    res.kind           = ccfr_pkg::KIND_DATA;
    res.data_byte      = 8'd0;
    res.data_index     = 8'd0;
    res.frame_address  = addr_r;
    res.payload_length = frame_len_r;
    if (q_pop) begin
      if (q_event.is_tick) begin
        if (phase_r == ccfr_pkg::PH_HUNT) begin
          silence_nxt = 16'd0;
        end else if (timed_out) begin
          silence_nxt = 16'd0;
          emit        = 1'b1;
          res.kind    = ccfr_pkg::KIND_TIMEOUT;
        end else begin
          silence_nxt = sil_inc;
        end
      end else begin
        silence_nxt = 16'd0;
        case (phase_r)
          ccfr_pkg::PH_HUNT: begin
            if (q_event.is_sync) begin
              crc_nxt        = crc_upd;
              addr_nxt       = 8'd0;
              frame_len_nxt  = 8'd0;
              byte_count_nxt = 8'd0;
            end
          end
          ccfr_pkg::PH_ADDR: begin
            addr_nxt = q_event.rx_byte;
            crc_nxt  = crc_upd;
          end
          ccfr_pkg::PH_LEN: begin
            if (q_event.len_short) begin
              frame_len_nxt      = 8'd0;
              emit               = 1'b1;
              res.kind           = ccfr_pkg::KIND_BADLEN;
              res.payload_length = 8'd0;
            end else begin
              frame_len_nxt  = q_event.len_m5;
              crc_nxt        = crc_upd;
              byte_count_nxt = 8'd0;
            end
          end
          ccfr_pkg::PH_DATA: begin
            crc_nxt        = crc_upd;
            byte_count_nxt = cnt_inc;
            emit           = 1'b1;
            res.data_byte  = q_event.rx_byte;
            res.data_index = byte_count_r;
          end
          ccfr_pkg::PH_CRCL: crc_low_nxt = q_event.rx_byte;
          ccfr_pkg::PH_CRCH: begin
            emit     = 1'b1;
            res.kind = crc_match ? ccfr_pkg::KIND_GOOD : ccfr_pkg::KIND_CRCERR;
          end
          default: emit = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_valid && cfg_ready) begin
      timeout_nxt = cfg_data;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ccfr_pkg::PH_HUNT;
      timeout_r    <= ccfr_pkg::TIMEOUT_RESET;
      frame_len_r  <= 8'd0;
      byte_count_r <= 8'd0;
      crc_r        <= 16'd0;
      crc_low_r    <= 8'd0;
      addr_r       <= 8'd0;
      silence_r    <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      timeout_r    <= timeout_nxt;
      frame_len_r  <= frame_len_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      crc_low_r    <= crc_low_nxt;
      addr_r       <= addr_nxt;
      silence_r    <= silence_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Every verdict closes the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit && (res.kind != ccfr_pkg::KIND_DATA) |=> phase_r == ccfr_pkg::PH_HUNT)
    else $error("verdict without return to hunt");
  // A result is only produced when the output register has room.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("result would overwrite pending transfer");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind != ccfr_pkg::KIND_DATA) |->
      (res_r.data_byte == 8'd0) && (res_r.data_index == 8'd0))
    else $error("verdict carries data fields");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ccfr_pkg::PH_HUNT) |-> (silence_r == 16'd0))
    else $error("silence counted while hunting");

endmodule

[rtl/core/ccnet_frame_receiver_top.sv]
// Top level of the serial frame receiver: front, event queue and back.
// Each input transfer is a received byte (in_func 0) or one silence tick (in_func 1).
// The block takes one transfer per clock cycle while in_ready is high and gives at most one
// result per transfer. An item passes through the four-entry event queue and then the output
// register before its output transfer. Throughput is set by the back-end state machine,
// which retires one queued event per cycle, doing any byte CRC-16 update (reflected,
// polynomial 0x8408) in that cycle, and stalls only while a result waits on out_ready;
// in_ready drops once the queue fills behind such a stall. Payload bytes stream out as they
// arrive; a verdict (good, bad length, CRC error, timeout) closes each frame. The timeout
// register is written through the cfg_ port, always ready, and resets to 20 ticks.
module ccnet_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_data_index,
  output logic [7:0]  out_frame_address,
  output logic [7:0]  out_payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ccfr_pkg::q_status_t q_status;
  ccfr_pkg::event_t    push_event;
  ccfr_pkg::event_t    head_event;
  ccfr_pkg::result_t   result;
  logic                q_push;
  logic                q_pop;

  ccfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_event    (push_event)
  );

  ccfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_event (push_event),
    .pop        (q_pop),
    .head_event (head_event),
    .status     (q_status)
  );

  ccfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .q_event    (head_event),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_kind           = result.kind;
  assign out_data_byte      = result.data_byte;
  assign out_data_index     = result.data_index;
  assign out_frame_address  = result.frame_address;
  assign out_payload_length = result.payload_length;

endmodule
